[design/ihex_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and result kinds for the Intel HEX parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_OK         = 2'd1,
      KIND_CSUM_ERR   = 2'd2,
      KIND_FORMAT_ERR = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_LEN  = 7'b0000010,
      PH_ADDR = 7'b0000100,
      PH_TYPE = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_CSUM = 7'b0100000,
      PH_SKIP = 7'b1000000
   } phase_type;

   // bit 4 set marks a character that is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      case (c) inside
         [8'h30:8'h39]: v = {1'b0, c[3:0]};
         [8'h41:8'h46],
         [8'h61:8'h66]: v = {1'b0, c[3:0] + 4'd9};
         default:       v = 5'h10;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[design/intel_hex_record_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Parses a stream of ASCII characters into Intel HEX data bytes and
// record-end status items.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while no result is left waiting in
// the output register; only such a waiting result holds back the input. Each
// accepted character is held in an input register, decoded against the parser
// state, and its result, if any, is loaded into the output register, from
// which it is offered. Data bytes are issued as soon as they are decoded,
// before the record checksum is known: a record whose end item reports a
// checksum error must be dropped downstream. After a format error the parser
// ignores everything up to the next line feed.
module intel_hex_record_parser
   import ihex_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_byte_address,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_record_type,
   output logic [7:0]       rsp_record_length
);

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [3:0]  nibble_high_ff, nibble_high_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic [7:0]  length_reg_ff, length_reg_in;
   logic [15:0] address_reg_ff, address_reg_in;
   logic [7:0]  type_reg_ff, type_reg_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  running_sum_ff, running_sum_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff, out_kind_in;
   logic [15:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [7:0]  out_type_ff, out_type_in;
   logic [7:0]  out_len_ff, out_len_in;

   logic        s1_advance;
   logic        emit;
   logic [4:0]  hex_d;
   logic [3:0]  d;
   logic [7:0]  b;
   logic [2:0]  dc_next;
   logic [7:0]  sum_next;
   logic [7:0]  index_next;
   logic [15:0] addr_shift;

   assign s1_advance  = !out_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   assign hex_d      = hex_value(s1_char_ff);
   assign d          = hex_d[3:0];
   assign b          = {nibble_high_ff, d};
   assign dc_next    = digit_count_ff + 3'd1;
   assign sum_next   = running_sum_ff + b;
   assign index_next = byte_index_ff + 8'd1;
   assign addr_shift = {address_reg_ff[11:0], d};

   always_comb begin
      phase_in       = phase_ff;
      nibble_high_in = nibble_high_ff;
      digit_count_in = digit_count_ff;
      length_reg_in  = length_reg_ff;
      address_reg_in = address_reg_ff;
      type_reg_in    = type_reg_ff;
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      emit           = 1'b0;
      out_kind_in    = KIND_FORMAT_ERR;
      out_addr_in    = address_reg_ff;
      out_data_in    = 8'd0;

      case (phase_ff)
         PH_IDLE: begin
            if (s1_char_ff == CH_COLON) begin
               phase_in       = PH_LEN;
               nibble_high_in = 4'd0;
               digit_count_in = 3'd0;
               length_reg_in  = 8'd0;
               address_reg_in = 16'd0;
               type_reg_in    = 8'd0;
               byte_index_in  = 8'd0;
               running_sum_in = 8'd0;
            end else if (s1_char_ff != CH_CR && s1_char_ff != CH_LF) begin
               emit     = 1'b1;
               phase_in = PH_SKIP;
            end
         end
         PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
            if (hex_d[4]) begin
               emit     = 1'b1;
               phase_in = (s1_char_ff == CH_LF) ? PH_IDLE : PH_SKIP;
            end else if (dc_next[0]) begin
               // first digit of a byte
               digit_count_in = dc_next;
               nibble_high_in = d;
               if (phase_ff == PH_ADDR) address_reg_in = addr_shift;
            end else begin
               digit_count_in = 3'd0;
               running_sum_in = sum_next;
               case (phase_ff)
                  PH_LEN: begin
                     length_reg_in = b;
                     phase_in      = PH_ADDR;
                  end
                  PH_ADDR: begin
                     address_reg_in = addr_shift;
                     if (dc_next < 3'd4) begin
                        digit_count_in = dc_next;
                     end else begin
                        phase_in = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     type_reg_in = b;
                     phase_in    = (length_reg_ff == 8'd0) ? PH_CSUM : PH_DATA;
                  end
                  PH_DATA: begin
                     emit          = 1'b1;
                     out_kind_in   = KIND_DATA;
                     out_addr_in   = address_reg_ff + {8'd0, byte_index_ff};
                     out_data_in   = b;
                     byte_index_in = index_next;
                     if (index_next == length_reg_ff) phase_in = PH_CSUM;
                  end
                  default: begin
                     emit        = 1'b1;
                     out_kind_in = (sum_next == 8'd0) ? KIND_OK : KIND_CSUM_ERR;
                     phase_in    = PH_IDLE;
                  end
               endcase
            end
         end
         default: begin
            // skipping to end of line
            if (s1_char_ff == CH_LF) phase_in = PH_IDLE;
         end
      endcase
   end

   assign out_type_in  = type_reg_ff;
   assign out_len_in   = length_reg_ff;
   assign out_valid_in = (s1_valid_ff && s1_advance) ? emit
                       : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         nibble_high_ff <= 4'd0;
         digit_count_ff <= 3'd0;
         length_reg_ff  <= 8'd0;
         address_reg_ff <= 16'd0;
         type_reg_ff    <= 8'd0;
         byte_index_ff  <= 8'd0;
         running_sum_ff <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_valid_ff && s1_advance) begin
            phase_ff       <= phase_in;
            nibble_high_ff <= nibble_high_in;
            digit_count_ff <= digit_count_in;
            length_reg_ff  <= length_reg_in;
            address_reg_ff <= address_reg_in;
            type_reg_ff    <= type_reg_in;
            byte_index_ff  <= byte_index_in;
            running_sum_ff <= running_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) s1_char_ff <= req_char_in;
      if (s1_valid_ff && s1_advance && emit) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
         out_data_ff <= out_data_in;
         out_type_ff <= out_type_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_byte_address  = out_addr_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_record_type   = out_type_ff;
   assign rsp_record_length = out_len_ff;

`ifndef NO_ASSERTIONS
   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not reach the input register");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != KIND_DATA |-> out_data_ff == 8'd0)
      else $error("status item carries a data byte");

   a_record_end_idle: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_advance && emit
      && (out_kind_in == KIND_OK || out_kind_in == KIND_CSUM_ERR)
      |=> phase_ff == PH_IDLE)
      else $error("parser not idle after record end");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> byte_index_ff < length_reg_ff)
      else $error("byte index ran past record length");
`endif

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Intel HEX record parser. A short table of
// directed characters comes first, then random records, broken records and
// line noise. Every accepted character is run through a local model of the
// parser, and each result item is checked field by field against the oldest
// prediction, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import ihex_pkg::*;

   localparam int ITEMS      = 1650;
   localparam int QUIET_AT   = 1450;
   localparam int DRAIN_STEP = 400;
   localparam int CYCLE_CAP  = 600000;

   typedef struct packed {
      logic        hit;
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [7:0]  rtype;
      logic [7:0]  rlen;
   } hex_result_type;

   typedef struct {
      logic [7:0]  chr;
      bit          fixed;
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  rtype;
      logic [7:0]  rlen;
   } stim_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_byte_address;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_record_length;

   intel_hex_record_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_record_type   (rsp_record_type),
      .rsp_record_length (rsp_record_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parser model state
   phase_type   st_phase = PH_IDLE;
   logic [3:0]  st_nibble = '0;
   logic [2:0]  st_digits = '0;
   logic [7:0]  st_len = '0;
   logic [15:0] st_addr = '0;
   logic [7:0]  st_type = '0;
   logic [7:0]  st_index = '0;
   logic [7:0]  st_sum = '0;

   hex_result_type pending_results [$];
   stim_row_type   dir_rows [24];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  chars_sent = 0;
   int  live_chars = 0;
   int  records_sent = 0;
   int  n_data = 0;
   int  n_ok = 0;
   int  n_csum = 0;
   int  n_fmt = 0;
   int  tx_pct = 10;
   bit  quiet = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // bit 4 flags a character outside 0-9, A-F, a-f
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
      else return 5'h10;
      return {1'b0, t[3:0]};
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      if ($urandom_range(0, 1) == 0) return 8'h37 + {4'h0, n};
      return 8'h57 + {4'h0, n};
   endfunction

   function automatic hex_result_type make_result(input kind_type k,
                                                  input logic [15:0] a,
                                                  input logic [7:0] d);
      hex_result_type r;
      r.hit   = 1'b1;
      r.kind  = k;
      r.addr  = a;
      r.data  = d;
      r.rtype = st_type;
      r.rlen  = st_len;
      return r;
   endfunction

   // advances the parser model by one character
   function automatic hex_result_type decode_char(input logic [7:0] c);
      hex_result_type r;
      logic [4:0]     d;
      logic [7:0]     b;
      r = '0;
      if (st_phase == PH_IDLE) begin
         if (c == CH_COLON) begin
            st_phase  = PH_LEN;
            st_nibble = '0;
            st_digits = '0;
            st_len    = '0;
            st_addr   = '0;
            st_type   = '0;
            st_index  = '0;
            st_sum    = '0;
         end else if (c != CH_CR && c != CH_LF) begin
            r = make_result(KIND_FORMAT_ERR, st_addr, 8'h00);
            st_phase = PH_SKIP;
         end
         return r;
      end
      if (st_phase == PH_SKIP) begin
         if (c == CH_LF) st_phase = PH_IDLE;
         return r;
      end
      d = nibble_of(c);
      if (d[4]) begin
         r = make_result(KIND_FORMAT_ERR, st_addr, 8'h00);
         st_phase = (c == CH_LF) ? PH_IDLE : PH_SKIP;
         return r;
      end
      st_digits = st_digits + 3'd1;
      if (st_digits[0]) begin
         st_nibble = d[3:0];
         if (st_phase == PH_ADDR) st_addr = {st_addr[11:0], d[3:0]};
         return r;
      end
      b = {st_nibble, d[3:0]};
      case (st_phase)
         PH_LEN: begin
            st_len    = b;
            st_sum    = st_sum + b;
            st_digits = '0;
            st_phase  = PH_ADDR;
         end
         PH_ADDR: begin
            st_addr = {st_addr[11:0], d[3:0]};
            st_sum  = st_sum + b;
            if (st_digits >= 3'd4) begin
               st_digits = '0;
               st_phase  = PH_TYPE;
            end
         end
         PH_TYPE: begin
            st_type   = b;
            st_sum    = st_sum + b;
            st_digits = '0;
            st_phase  = (st_len == 8'd0) ? PH_CSUM : PH_DATA;
         end
         PH_DATA: begin
            r = make_result(KIND_DATA, st_addr + {8'h00, st_index}, b);
            st_sum    = st_sum + b;
            st_index  = st_index + 8'd1;
            st_digits = '0;
            if (st_index == st_len) st_phase = PH_CSUM;
         end
         default: begin
            st_sum = st_sum + b;
            r = make_result((st_sum == 8'd0) ? KIND_OK : KIND_CSUM_ERR, st_addr, 8'h00);
            st_digits = '0;
            st_phase  = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   task automatic send_char(input logic [7:0] c, input bit use_fixed,
                            input hex_result_type fixed_res);
      hex_result_type r;
      bit             live;
      if (!quiet && tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_ready);
      live = (st_phase != PH_SKIP);
      r = decode_char(c);
      if (use_fixed) r = fixed_res;
      if (r.hit) pending_results.push_back(r);
      chars_sent++;
      if (live) live_chars++;
   endtask

   // hold the sender off until every predicted item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_record();
      logic [7:0]  bytes_q [$];
      logic [7:0]  chars_q [$];
      int          len;
      int          sel;
      int          p;
      bit          broken;
      logic [15:0] addr;
      logic [7:0]  rtype;
      logic [7:0]  sum;
      sel = $urandom_range(0, 149);
      if (sel == 0) len = $urandom_range(200, 255);
      else if (sel < 40) len = $urandom_range(5, 16);
      else len = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) addr = 16'hFFF0 + 16'($urandom_range(0, 15));
      else addr = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 19);
      if (sel < 14) rtype = 8'h00;
      else if (sel < 17) rtype = 8'h01;
      else rtype = 8'($urandom_range(0, 255));
      bytes_q.push_back(8'(len));
      bytes_q.push_back(addr[15:8]);
      bytes_q.push_back(addr[7:0]);
      bytes_q.push_back(rtype);
      for (int i = 0; i < len; i++) bytes_q.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (bytes_q[i]) sum = sum + bytes_q[i];
      sum = 8'h00 - sum;
      if ($urandom_range(0, 4) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      bytes_q.push_back(sum);
      chars_q.push_back(CH_COLON);
      foreach (bytes_q[i]) begin
         chars_q.push_back(digit_char(bytes_q[i][7:4]));
         chars_q.push_back(digit_char(bytes_q[i][3:0]));
      end
      broken = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
         p = $urandom_range(1, chars_q.size() - 1);
         case ($urandom_range(0, 3))
            0: chars_q[p] = CH_LF;
            1: chars_q[p] = CH_CR;
            2: chars_q[p] = CH_COLON;
            default: chars_q[p] = 8'($urandom_range(0, 255));
         endcase
         broken = 1'b1;
      end
      case ($urandom_range(0, 3))
         1: chars_q.push_back(CH_LF);
         2: begin
            chars_q.push_back(CH_CR);
            chars_q.push_back(CH_LF);
         end
         3: chars_q.push_back(CH_CR);
         default: ;
      endcase
      // a broken record can leave the parser skipping, so end the line
      if (broken) chars_q.push_back(CH_LF);
      foreach (chars_q[i]) send_char(chars_q[i], 1'b0, '0);
      records_sent++;
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 9);
      if ($urandom_range(0, 1) == 0) begin
         // raw bytes, then end of line
         for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
         // record cut short by a line feed
         send_char(CH_COLON, 1'b0, '0);
         for (int i = 0; i < n; i++) send_char(digit_char(4'($urandom_range(0, 15))), 1'b0, '0);
      end
      send_char(CH_LF, 1'b0, '0);
   endtask

   // result side: check each accepted item, stall in random bursts
   initial begin
      hex_result_type want;
      int             stall_left;
      int             rx_pct;
      int             tick;
      stall_left = 0;
      rx_pct     = 10;
      tick       = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected item: kind %0d address %h", rsp_kind, rsp_byte_address);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d actual %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_byte_address !== want.addr) begin
                  $error("byte_address: expected %h actual %h", want.addr, rsp_byte_address);
                  fail_count++;
               end
               if (rsp_data_byte !== want.data) begin
                  $error("data_byte: expected %h actual %h", want.data, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_record_type !== want.rtype) begin
                  $error("record_type: expected %h actual %h", want.rtype, rsp_record_type);
                  fail_count++;
               end
               if (rsp_record_length !== want.rlen) begin
                  $error("record_length: expected %h actual %h", want.rlen,
                         rsp_record_length);
                  fail_count++;
               end
               case (want.kind)
                  KIND_DATA:     n_data++;
                  KIND_OK:       n_ok++;
                  KIND_CSUM_ERR: n_csum++;
                  default:       n_fmt++;
               endcase
            end
         end
         tick++;
         if (tick % 200 == 0) begin
            case ($urandom_range(0, 3))
               0: rx_pct = 0;
               1: rx_pct = 5;
               2: rx_pct = 20;
               default: rx_pct = 40;
            endcase
         end
         if (reset) rsp_ready <= 1'b0;
         else if (quiet) rsp_ready <= 1'b1;
         else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rx_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      hex_result_type fixed_res;
      int             next_drain;
      dir_rows = '{
         // stray characters while idle, colon while skipping
         '{8'h00,    1'b1, KIND_FORMAT_ERR, 16'h0000, 8'h00, 8'h00},
         '{8'hFF,    1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{CH_COLON, 1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{CH_LF,    1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{8'hFF,    1'b1, KIND_FORMAT_ERR, 16'h0000, 8'h00, 8'h00},
         '{CH_LF,    1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         // carriage return inside a record
         '{CH_COLON, 1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{CH_CR,    1'b1, KIND_FORMAT_ERR, 16'h0000, 8'h00, 8'h00},
         '{CH_LF,    1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         // zero-length end-of-file record
         '{CH_COLON, 1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"0",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"1",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"F",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"f",      1'b1, KIND_OK,         16'h0000, 8'h01, 8'h00},
         // line feed inside a record goes straight back to idle
         '{CH_COLON, 1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{"1",      1'b0, KIND_DATA,       16'h0000, 8'h00, 8'h00},
         '{CH_LF,    1'b1, KIND_FORMAT_ERR, 16'h0000, 8'h00, 8'h00}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         fixed_res.hit   = 1'b1;
         fixed_res.kind  = dir_rows[i].kind;
         fixed_res.addr  = dir_rows[i].addr;
         fixed_res.data  = 8'h00;
         fixed_res.rtype = dir_rows[i].rtype;
         fixed_res.rlen  = dir_rows[i].rlen;
         send_char(dir_rows[i].chr, dir_rows[i].fixed, fixed_res);
      end
      drain_results();

      next_drain = live_chars + DRAIN_STEP;
      while (live_chars < ITEMS) begin
         // no pauses once the closing stretch has started
         if (live_chars < QUIET_AT && live_chars >= next_drain) begin
            drain_results();
            next_drain = live_chars + DRAIN_STEP;
         end
         if (live_chars >= QUIET_AT) quiet = 1'b1;
         case ($urandom_range(0, 3))
            0, 1: tx_pct = 0;
            2: tx_pct = 10;
            default: tx_pct = 30;
         endcase
         if ($urandom_range(0, 9) < 8) send_record();
         else send_noise();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (8) @(posedge clock);
      $display("covered %0d characters (%0d parsed) in %0d random records plus noise",
               chars_sent, live_chars, records_sent);
      $display("checked %0d data bytes, %0d good records, %0d checksum and %0d format errors",
               n_data, n_ok, n_csum, n_fmt);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
